// ----- rtl/i2cra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_pkg
// Shared types and constants of the I2C register access master.
// ----------------------------------------------------------------------------
package i2cra_pkg;

    localparam logic [6:0] DEV_ADDR_RESET = 7'h68;

    // Command codes on the input channel
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        K_TICK  = 3'b001,
        K_WRITE = 3'b010,
        K_READ  = 3'b100
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  reg_addr;
        logic [7:0]  write_data;
        logic        sda_in;
    } t_item;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    typedef enum logic [9:0] {
        OP_END    = 10'b00_0000_0001,
        OP_START  = 10'b00_0000_0010,
        OP_ADDR_W = 10'b00_0000_0100,
        OP_ADDR_R = 10'b00_0000_1000,
        OP_REG    = 10'b00_0001_0000,
        OP_DATA   = 10'b00_0010_0000,
        OP_ACK    = 10'b00_0100_0000,
        OP_RECV   = 10'b00_1000_0000,
        OP_NACK   = 10'b01_0000_0000,
        OP_STOP   = 10'b10_0000_0000
    } t_op;

    function automatic t_op seq_op(input logic is_read, input logic [3:0] seg);
        t_op op;
        op = OP_END;
        if (is_read) begin
            unique case (seg)
                4'd0:    op = OP_START;
                4'd1:    op = OP_ADDR_W;
                4'd2:    op = OP_ACK;
                4'd3:    op = OP_REG;
                4'd4:    op = OP_ACK;
                4'd5:    op = OP_START;
                4'd6:    op = OP_ADDR_R;
                4'd7:    op = OP_ACK;
                4'd8:    op = OP_RECV;
                4'd9:    op = OP_NACK;
                4'd10:   op = OP_STOP;
                default: op = OP_END;
            endcase
        end else begin
            unique case (seg)
                4'd0:    op = OP_START;
                4'd1:    op = OP_ADDR_W;
                4'd2:    op = OP_ACK;
                4'd3:    op = OP_REG;
                4'd4:    op = OP_ACK;
                4'd5:    op = OP_DATA;
                4'd6:    op = OP_ACK;
                4'd7:    op = OP_STOP;
                default: op = OP_END;
            endcase
        end
        return op;
    endfunction

endpackage

// ----- rtl/i2c_master_register_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Open-drain I2C master for single register writes and reads.
// ----------------------------------------------------------------------------
// One transaction is taken every clock and each yields one result. The
// transaction waits at the head of the two-entry input queue, and the
// sequencer writes the result register from there. A stalled result holds
// the sequencer, and the input stalls once the queue holds two transactions.
// The sequencer performs one pin step per cycle while tick transactions are
// queued and no result is stalled. Write and read commands are only
// honoured while the bus sequence is idle; each tick transaction advances
// the sequence by one pin step.
module i2c_master_register_access
    import i2cra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_data,
    output logic       o_nack_seen
);

    logic [6:0] r_dev_addr;
    t_head      w_head;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
        end
    end

    i2cra_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .i_pop        (w_pop),
        .o_head       (w_head)
    );

    i2cra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dev_addr  (r_dev_addr),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl_out   (o_scl_out),
        .o_sda_out   (o_sda_out),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_read_data (o_read_data),
        .o_nack_seen (o_nack_seen)
    );

`ifndef SYNTHESIS
    // The sequencer never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    // Stop completion leaves the bus released and the sequencer idle
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_scl_out && o_sda_out && !o_busy_res))
        else $error("stop did not release the bus");

    // A popped transaction reaches the result register in the next cycle
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_valid)
        else $error("result lost");
`endif

endmodule

// ----- rtl/i2cra_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_front
// Accepts input transactions, classifies the command and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module i2cra_front
    import i2cra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    input  logic       i_pop,
    output t_head      o_head
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    t_item      w_item;

    always_comb begin
        w_item.reg_addr   = i_reg_addr;
        w_item.write_data = i_write_data;
        w_item.sda_in     = i_sda_in;
        unique case (i_command)
            CMD_WRITE: w_item.kind = K_WRITE;
            CMD_READ:  w_item.kind = K_READ;
            default:   w_item.kind = K_TICK;  // unused code runs as a tick
        endcase
    end

    assign o_stall     = (r_count == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

// ----- rtl/i2cra_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cra_back
// Bus sequencer: one pin step per tick, with the result register.
// ----------------------------------------------------------------------------
module i2cra_back
    import i2cra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [6:0] i_dev_addr,
    input  t_head      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_data,
    output logic       o_nack_seen
);

    t_state     r_state, n_state;
    logic [3:0] r_seg, n_seg;
    logic [1:0] r_sub, n_sub;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_captured, n_captured;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_is_read, n_is_read;
    logic       r_nack, n_nack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       n_done;
    logic       r_ovalid;
    t_op        w_op;
    logic [7:0] w_byte;
    t_item      w_it;

    assign w_it  = i_head.item;
    assign o_pop = i_head.valid && (!r_ovalid || !i_stall);
    assign w_op  = seq_op(r_is_read, r_seg);

    always_comb begin
        unique case (w_op)
            OP_ADDR_W: w_byte = {i_dev_addr, 1'b0};
            OP_ADDR_R: w_byte = {i_dev_addr, 1'b1};
            OP_REG:    w_byte = r_reg;
            default:   w_byte = r_data;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_seg      = r_seg;
        n_sub      = r_sub;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_captured = r_captured;
        n_reg      = r_reg;
        n_data     = r_data;
        n_is_read  = r_is_read;
        n_nack     = r_nack;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_done     = 1'b0;
        if (w_it.kind != K_TICK) begin
            if (r_state == ST_IDLE) begin
                n_state   = ST_BUSY;
                n_reg     = w_it.reg_addr;
                n_data    = w_it.write_data;
                n_is_read = (w_it.kind == K_READ);
                n_nack    = 1'b0;
                n_bit     = 3'd0;
                n_seg     = 4'd0;
                n_sub     = 2'd0;
            end
        end else if (r_state == ST_BUSY) begin
            unique case (w_op)
                OP_START: begin
                    unique case (r_sub)
                        2'd0: n_sda = 1'b1;
                        2'd1: n_scl = 1'b1;
                        2'd2: n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                    n_sub = r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        n_seg = r_seg + 4'd1;
                        n_bit = 3'd0;
                    end
                end
                OP_ADDR_W, OP_ADDR_R, OP_REG, OP_DATA: begin
                    priority if (r_sub == 2'd0) begin
                        n_sda = w_byte[3'd7 - r_bit];
                        n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_scl = 1'b1;
                        n_sub = 2'd2;
                    end else begin
                        n_scl = 1'b0;
                        n_sub = 2'd0;
                        n_bit = r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            n_seg = r_seg + 4'd1;
                        end
                    end
                end
                OP_ACK: begin
                    unique case (r_sub)
                        2'd0: n_sda = 1'b1;
                        2'd1: n_scl = 1'b1;
                        2'd2: n_nack = r_nack | w_it.sda_in;
                        default: n_scl = 1'b0;
                    endcase
                    n_sub = r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        n_seg = r_seg + 4'd1;
                        n_bit = 3'd0;
                    end
                end
                OP_RECV: begin
                    unique case (r_sub)
                        2'd0: begin
                            n_sda   = 1'b1;
                            n_shift = 8'd0;
                            n_sub   = 2'd1;
                        end
                        2'd1: begin
                            n_scl = 1'b1;
                            n_sub = 2'd2;
                        end
                        2'd2: begin
                            n_shift = {r_shift[6:0], w_it.sda_in};
                            n_sub   = 2'd3;
                        end
                        default: begin
                            n_scl = 1'b0;
                            n_bit = r_bit + 3'd1;
                            if (r_bit == 3'd7) begin
                                n_captured = r_shift;
                                n_seg      = r_seg + 4'd1;
                                n_sub      = 2'd0;
                            end else begin
                                n_sub = 2'd1;
                            end
                        end
                    endcase
                end
                OP_NACK: begin
                    priority if (r_sub == 2'd0) begin
                        n_sda = 1'b1;
                        n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_scl = 1'b1;
                        n_sub = 2'd2;
                    end else begin
                        n_scl = 1'b0;
                        n_sub = 2'd0;
                        n_seg = r_seg + 4'd1;
                        n_bit = 3'd0;
                    end
                end
                OP_STOP: begin
                    priority if (r_sub == 2'd0) begin
                        n_sda = 1'b0;
                        n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_scl = 1'b1;
                        n_sub = 2'd2;
                    end else begin
                        n_sda   = 1'b1;
                        n_state = ST_IDLE;
                        n_bit   = 3'd0;
                        n_done  = 1'b1;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                    n_bit   = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seg      <= 4'd0;
            r_sub      <= 2'd0;
            r_bit      <= 3'd0;
            r_shift    <= 8'd0;
            r_captured <= 8'd0;
            r_reg      <= 8'd0;
            r_data     <= 8'd0;
            r_is_read  <= 1'b0;
            r_nack     <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_ovalid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state    <= n_state;
                r_seg      <= n_seg;
                r_sub      <= n_sub;
                r_bit      <= n_bit;
                r_shift    <= n_shift;
                r_captured <= n_captured;
                r_reg      <= n_reg;
                r_data     <= n_data;
                r_is_read  <= n_is_read;
                r_nack     <= n_nack;
                r_scl      <= n_scl;
                r_sda      <= n_sda;
                r_ovalid   <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_scl_out   <= n_scl;
            o_sda_out   <= n_sda;
            o_busy_res  <= (n_state == ST_BUSY);
            o_done_res  <= n_done;
            o_read_data <= n_captured;
            o_nack_seen <= n_nack;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C register access master. A short directed
// table covers idle ticks, the spare command code, commands while busy and
// operand extremes. Random write and read transactions follow, stepped pin by
// pin with random SDA samples. Each phase uses its own device address and its
// own pattern of sender gaps and receiver stalls. Every result is checked
// against the typed row value or, otherwise, a local bus-level predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cra_pkg::*;

    localparam logic [1:0] CMD_SPARE    = 2'd3;
    localparam int         PHASE_ITEMS  = 170;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         NUM_DIR      = 20;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       nack;
    } t_bus_res;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_addr;
        logic [7:0] wdata;
        logic       sda;
        logic       typed;
        t_bus_res   res;
    } t_dir_row;

    localparam t_bus_res RES_IDLE = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam t_bus_res RES_BUSY = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam t_bus_res RES_NONE = '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [6:0] i_cfg_wr_data;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_command;
    logic [7:0] i_reg_addr;
    logic [7:0] i_write_data;
    logic       i_sda_in;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_scl_out;
    logic       o_sda_out;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_read_data;
    logic       o_nack_seen;

    i2c_master_register_access u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_data   (o_read_data),
        .o_nack_seen   (o_nack_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bus predictor state
    logic [6:0] dev_addr;
    logic       bus_idle;
    logic [3:0] seg;
    logic [1:0] sub;
    logic [2:0] bit_idx;
    logic [7:0] rx_shift;
    logic [7:0] rx_byte;
    logic [7:0] reg_latch;
    logic [7:0] data_latch;
    logic       rd_txn;
    logic       nack_latch;
    logic       scl_q;
    logic       sda_q;

    t_op wr_plan [0:7]  = '{OP_START, OP_ADDR_W, OP_ACK, OP_REG, OP_ACK, OP_DATA, OP_ACK,
                            OP_STOP};
    t_op rd_plan [0:10] = '{OP_START, OP_ADDR_W, OP_ACK, OP_REG, OP_ACK, OP_START, OP_ADDR_R,
                            OP_ACK, OP_RECV, OP_NACK, OP_STOP};

    t_bus_res level_q [$];
    int       err_cnt     = 0;
    int       quiet_cycles = 0;
    int       tx_gap_pct  = 0;
    int       rx_stall_pct = 0;
    bit       ack_noise   = 1'b1;

    t_dir_row dir_rows [NUM_DIR] = '{
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_IDLE},
        '{CMD_SPARE, 8'hFF, 8'hFF, 1'b0, 1'b1, RES_IDLE},
        '{CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, RES_BUSY},
        '{CMD_READ,  8'h00, 8'hFF, 1'b1, 1'b1, RES_BUSY},
        '{CMD_WRITE, 8'h55, 8'hAA, 1'b1, 1'b1, RES_BUSY},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{CMD_TICK,  8'hFF, 8'hFF, 1'b1, 1'b0, RES_NONE},
        '{CMD_SPARE, 8'h5A, 8'hA5, 1'b1, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{CMD_READ,  8'h12, 8'h34, 1'b0, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{CMD_SPARE, 8'h00, 8'h00, 1'b1, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, RES_NONE},
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b0, RES_NONE}
    };

    function automatic t_op plan_op(input logic rd, input logic [3:0] s);
        if (rd) begin
            return (s <= 4'd10) ? rd_plan[s] : OP_END;
        end
        return (s <= 4'd7) ? wr_plan[s[2:0]] : OP_END;
    endfunction

    function automatic void advance_seg();
        seg     = seg + 4'd1;
        sub     = 2'd0;
        bit_idx = 3'd0;
    endfunction

    // Pin levels and status after one transaction
    function automatic t_bus_res next_bus_levels(input logic [1:0] cmd, input logic [7:0] ra,
                                                 input logic [7:0] wd, input logic sda);
        t_op        op;
        logic [7:0] tx;
        logic       fin;
        fin = 1'b0;
        tx  = 8'h00;
        if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            if (bus_idle) begin
                reg_latch  = ra;
                data_latch = wd;
                rd_txn     = (cmd == CMD_READ);
                nack_latch = 1'b0;
                bit_idx    = 3'd0;
                seg        = 4'd0;
                sub        = 2'd0;
                bus_idle   = 1'b0;
            end
        end else if (!bus_idle) begin
            op = plan_op(rd_txn, seg);
            case (op)
                OP_START, OP_ACK: begin
                    case (sub)
                        2'd0: sda_q = 1'b1;
                        2'd1: scl_q = 1'b1;
                        2'd2: begin
                            if (op == OP_START) sda_q = 1'b0;
                            else if (sda) nack_latch = 1'b1;
                        end
                        default: scl_q = 1'b0;
                    endcase
                    if (sub == 2'd3) advance_seg();
                    else sub = sub + 2'd1;
                end
                OP_ADDR_W, OP_ADDR_R, OP_REG, OP_DATA: begin
                    if (sub == 2'd0) begin
                        case (op)
                            OP_ADDR_W: tx = {dev_addr, 1'b0};
                            OP_ADDR_R: tx = {dev_addr, 1'b1};
                            OP_REG:    tx = reg_latch;
                            default:   tx = data_latch;
                        endcase
                        sda_q = tx[3'd7 - bit_idx];
                        sub   = 2'd1;
                    end else if (sub == 2'd1) begin
                        scl_q = 1'b1;
                        sub   = 2'd2;
                    end else begin
                        scl_q = 1'b0;
                        if (bit_idx == 3'd7) begin
                            advance_seg();
                        end else begin
                            bit_idx = bit_idx + 3'd1;
                            sub     = 2'd0;
                        end
                    end
                end
                OP_RECV: begin
                    case (sub)
                        2'd0: begin
                            sda_q    = 1'b1;
                            rx_shift = 8'h00;
                            sub      = 2'd1;
                        end
                        2'd1: begin
                            scl_q = 1'b1;
                            sub   = 2'd2;
                        end
                        2'd2: begin
                            rx_shift = {rx_shift[6:0], sda};
                            sub      = 2'd3;
                        end
                        default: begin
                            scl_q = 1'b0;
                            if (bit_idx == 3'd7) begin
                                rx_byte = rx_shift;
                                advance_seg();
                            end else begin
                                bit_idx = bit_idx + 3'd1;
                                sub     = 2'd1;
                            end
                        end
                    endcase
                end
                OP_NACK: begin
                    if (sub == 2'd0) begin
                        sda_q = 1'b1;
                        sub   = 2'd1;
                    end else if (sub == 2'd1) begin
                        scl_q = 1'b1;
                        sub   = 2'd2;
                    end else begin
                        scl_q = 1'b0;
                        advance_seg();
                    end
                end
                OP_STOP: begin
                    if (sub == 2'd0) begin
                        sda_q = 1'b0;
                        sub   = 2'd1;
                    end else if (sub == 2'd1) begin
                        scl_q = 1'b1;
                        sub   = 2'd2;
                    end else begin
                        sda_q    = 1'b1;
                        bus_idle = 1'b1;
                        bit_idx  = 3'd0;
                        fin      = 1'b1;
                    end
                end
                default: begin
                    bus_idle = 1'b1;
                    bit_idx  = 3'd0;
                end
            endcase
        end
        return '{scl_q, sda_q, !bus_idle, fin, rx_byte, nack_latch};
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ra, input logic [7:0] wd,
                             input logic sda, input logic typed, input t_bus_res typed_res);
        t_bus_res lv;
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_reg_addr   <= ra;
        i_write_data <= wd;
        i_sda_in     <= sda;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        lv = next_bus_levels(cmd, ra, wd, sda);
        level_q.push_back(typed ? typed_res : lv);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_bus_res want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (level_q.size() == 0) begin
                $error("result transaction with nothing expected");
                err_cnt++;
            end else begin
                want = level_q.pop_front();
                check_field("scl_out",   8'(want.scl),  8'(o_scl_out));
                check_field("sda_out",   8'(want.sda),  8'(o_sda_out));
                check_field("busy_res",  8'(want.busy), 8'(o_busy_res));
                check_field("done_res",  8'(want.done), 8'(o_done_res));
                check_field("read_data", want.rdata,    o_read_data);
                check_field("nack_seen", 8'(want.nack), 8'(o_nack_seen));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [1:0] cmd;
        logic [7:0] ra;
        logic [7:0] wd;
        logic       sda;
        int         live;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 7'h00;
        i_valid       <= 1'b0;
        i_command     <= CMD_TICK;
        i_reg_addr    <= 8'h00;
        i_write_data  <= 8'h00;
        i_sda_in      <= 1'b1;
        dev_addr   = DEV_ADDR_RESET;
        bus_idle   = 1'b1;
        seg        = 4'd0;
        sub        = 2'd0;
        bit_idx    = 3'd0;
        rx_shift   = 8'h00;
        rx_byte    = 8'h00;
        reg_latch  = 8'h00;
        data_latch = 8'h00;
        rd_txn     = 1'b0;
        nack_latch = 1'b0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIR; k++) begin
            send_item(dir_rows[k].cmd, dir_rows[k].reg_addr, dir_rows[k].wdata,
                      dir_rows[k].sda, dir_rows[k].typed, dir_rows[k].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            if (ph != 0) begin
                while (level_q.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                case (ph)
                    1:       dev_addr = 7'h7F;
                    2:       dev_addr = 7'h00;
                    default: dev_addr = 7'($urandom_range(126, 1));
                endcase
                i_cfg_wr_en   <= 1'b1;
                i_cfg_wr_data <= dev_addr;
                @(posedge i_clk);
                i_cfg_wr_en   <= 1'b0;
            end
            case (ph)
                1:       begin tx_gap_pct = 64; rx_stall_pct = 0;  end
                2:       begin tx_gap_pct = 0;  rx_stall_pct = 64; end
                3:       begin tx_gap_pct = 21; rx_stall_pct = 21; end
                default: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            endcase
            live = 0;
            while (live < PHASE_ITEMS || !bus_idle) begin
                ra  = 8'($urandom);
                wd  = 8'($urandom);
                sda = 1'($urandom_range(1));
                if (bus_idle) begin
                    if ($urandom_range(99) < 6) begin
                        cmd = $urandom_range(1) ? CMD_TICK : CMD_SPARE;
                    end else begin
                        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                        case ($urandom_range(7))
                            0:       ra = 8'h00;
                            1:       ra = 8'hFF;
                            default: ;
                        endcase
                        case ($urandom_range(7))
                            0:       wd = 8'h00;
                            1:       wd = 8'hFF;
                            default: ;
                        endcase
                        ack_noise = ($urandom_range(3) == 0);
                        live++;
                    end
                end else if ($urandom_range(99) < 4) begin
                    cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                end else begin
                    cmd = ($urandom_range(9) == 0) ? CMD_SPARE : CMD_TICK;
                    if (plan_op(rd_txn, seg) == OP_ACK && !ack_noise) sda = 1'b0;
                    live++;
                end
                send_item(cmd, ra, wd, sda, 1'b0, RES_NONE);
            end
            i_valid <= 1'b0;
        end

        while (level_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/i2cra_pkg.sv
rtl/i2cra_front.sv
rtl/i2cra_back.sv
rtl/i2c_master_register_access.sv
verif/tb_top.sv
